>>> rtl/rsi_pkg.sv
// shared types, constants and codes for the rsi threshold signal block
package rsi_pkg;

    localparam int PRICE_W   = 24;
    localparam int FRAC_W    = 16;
    localparam int AVG_W     = PRICE_W + FRAC_W;
    localparam int PERIOD_W  = 7;
    localparam int NM1_W     = 6;
    localparam int CNT_W     = 7;
    localparam int THR_W     = 14;
    localparam int RSI_W     = 14;
    localparam int SIG_W     = 2;
    localparam int RMUL_W    = 15;
    localparam int SUM_W     = AVG_W + 1;
    localparam int DEN_W     = AVG_W + 2;
    localparam int SPROD_W   = AVG_W + NM1_W;
    localparam int SNUM_W    = AVG_W + PERIOD_W;
    localparam int RPROD_W   = AVG_W + RMUL_W;
    localparam int NUM_W     = RPROD_W + 1;
    localparam int REM_W     = DEN_W + 1;
    localparam int ITER_W    = $clog2(AVG_W + 1);

    localparam int PERIOD_MIN = 2;
    localparam int PERIOD_MAX = 64;
    localparam int RSI_SCALE  = 10000;
    localparam int RSI_HALF   = RSI_SCALE / 2;
    localparam int RSI_DOUBLE = RSI_SCALE * 2;

    localparam int RST_PERIOD = 14;
    localparam int RST_BUY    = 3000;
    localparam int RST_SELL   = 7000;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 14;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BUY    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SELL   = 2'd2;

    localparam logic [SIG_W-1:0] SIG_HOLD = 2'd0;
    localparam logic [SIG_W-1:0] SIG_BUY  = 2'd1;
    localparam logic [SIG_W-1:0] SIG_SELL = 2'd2;

    typedef struct packed {
        logic [PRICE_W-1:0] price;
        logic               restart;
    } t_item;

    typedef struct packed {
        logic               rsi_ready;
        logic [RSI_W-1:0]   rsi_value;
        logic [SIG_W-1:0]   signal;
    } t_result;

    typedef struct packed {
        logic [PERIOD_W-1:0] period;
        logic [THR_W-1:0]    buy;
        logic [THR_W-1:0]    sell;
    } t_cfg;

    typedef struct packed {
        logic               first;
        logic [PRICE_W-1:0] gain;
        logic [PRICE_W-1:0] loss;
    } t_cmd;

    typedef struct packed {
        logic              start;
        logic [DEN_W-1:0]  rem0;
        logic [AVG_W-1:0]  low;
        logic [ITER_W-1:0] iters;
        logic [DEN_W-1:0]  den;
    } t_div_req;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [AVG_W-1:0] quo;
    } t_div_rsp;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SMUL,
        S_SADD,
        S_DIVG_GO,
        S_DIVG_WAIT,
        S_DIVL_GO,
        S_DIVL_WAIT,
        S_RMUL,
        S_RADD,
        S_RDIV_GO,
        S_RDIV_WAIT,
        S_SIG,
        S_PUSH
    } t_back_state;

endpackage

>>> rtl/rsi_front.sv
// front end: keeps the previous price and turns each sample into a gain/loss command
module rsi_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  rsi_pkg::t_item i_item,
    output rsi_pkg::t_cmd  o_cmd
);
    import rsi_pkg::*;

    logic [PRICE_W-1:0] r_prev;
    logic               r_have;

    always_comb begin
        o_cmd.first = i_item.restart | ~r_have;
        if (i_item.price > r_prev) begin
            o_cmd.gain = i_item.price - r_prev;
            o_cmd.loss = '0;
        end else begin
            o_cmd.gain = '0;
            o_cmd.loss = r_prev - i_item.price;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
            r_have <= 1'b0;
        end else if (i_accept) begin
            r_prev <= i_item.price;
            r_have <= 1'b1;
        end
    end

endmodule

>>> rtl/rsi_cmd_fifo.sv
// two-entry command queue between front and back
module rsi_cmd_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  rsi_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output rsi_pkg::t_cmd o_head,
    output logic          o_full,
    output logic          o_empty
);
    import rsi_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;
    logic       w_push;
    logic       w_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_head  = r_mem[r_rptr];
    assign w_push  = i_push & ~o_full;
    assign w_pop   = i_pop & ~o_empty;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (w_push) begin
                r_wptr <= ~r_wptr;
            end
            if (w_pop) begin
                r_rptr <= ~r_rptr;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> rtl/rsi_div.sv
// serial restoring divider, one quotient bit per cycle
module rsi_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rsi_pkg::t_div_req i_req,
    output rsi_pkg::t_div_rsp o_rsp
);
    import rsi_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [ITER_W-1:0] r_cnt;
    logic [DEN_W-1:0]  r_rem;
    logic [AVG_W-1:0]  r_low;
    logic [AVG_W-1:0]  r_quo;
    logic [DEN_W-1:0]  r_den;
    logic [REM_W-1:0]  w_trial;
    logic [REM_W-1:0]  w_diff;
    logic              w_ge;

    assign w_trial = {r_rem, r_low[AVG_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_den});
    assign w_diff  = w_trial - {1'b0, r_den};

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

    always_ff @(posedge i_clk) begin
        if (i_req.start && !r_busy) begin
            r_rem <= i_req.rem0;
            r_low <= i_req.low;
            r_den <= i_req.den;
            r_cnt <= i_req.iters;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
            r_low <= {r_low[AVG_W-2:0], 1'b0};
            r_quo <= {r_quo[AVG_W-2:0], w_ge};
            r_cnt <= r_cnt - ITER_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == ITER_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

endmodule

>>> rtl/rsi_back.sv
// back end: seeding, wilder smoothing, rsi and signal, with the result register
module rsi_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rsi_pkg::t_cfg     i_cfg,
    input  rsi_pkg::t_cmd     i_cmd,
    input  logic              i_cmd_empty,
    output logic              o_cmd_pop,
    output rsi_pkg::t_div_req o_div_req,
    input  rsi_pkg::t_div_rsp i_div_rsp,
    output rsi_pkg::t_result  o_result,
    output logic              o_res_valid,
    input  logic              i_res_pop
);
    import rsi_pkg::*;

    t_back_state        r_state;
    t_back_state        n_state;
    logic               r_seeded;
    logic [CNT_W-1:0]   r_count;
    logic [AVG_W-1:0]   r_avg_g;
    logic [AVG_W-1:0]   r_avg_l;
    logic [PRICE_W-1:0] r_gain;
    logic [PRICE_W-1:0] r_loss;
    logic [SPROD_W-1:0] r_prod_g;
    logic [SPROD_W-1:0] r_prod_l;
    logic [SNUM_W-1:0]  r_num_g;
    logic [SNUM_W-1:0]  r_num_l;
    logic [PERIOD_W-1:0] r_den_s;
    logic [RPROD_W-1:0] r_prod_r;
    logic [SUM_W-1:0]   r_sum;
    logic [NUM_W-1:0]   r_num_r;
    logic [RSI_W-1:0]   r_rsi;
    t_result            r_res;
    t_result            r_out;
    logic               r_out_valid;

    logic [PERIOD_W-1:0] w_period;
    logic [NM1_W-1:0]    w_nm1;
    logic [AVG_W-1:0]    w_sum_g;
    logic [AVG_W-1:0]    w_sum_l;
    logic [CNT_W-1:0]    w_cnt_next;
    logic                w_seed_done;
    logic                w_slot;

    always_comb begin
        if (i_cfg.period < PERIOD_W'(PERIOD_MIN)) begin
            w_period = PERIOD_W'(PERIOD_MIN);
        end else if (i_cfg.period > PERIOD_W'(PERIOD_MAX)) begin
            w_period = PERIOD_W'(PERIOD_MAX);
        end else begin
            w_period = i_cfg.period;
        end
    end

    assign w_nm1       = NM1_W'(w_period - PERIOD_W'(1));
    assign w_sum_g     = r_avg_g + AVG_W'(i_cmd.gain);
    assign w_sum_l     = r_avg_l + AVG_W'(i_cmd.loss);
    assign w_cnt_next  = r_count + CNT_W'(1);
    assign w_seed_done = (w_cnt_next >= CNT_W'(w_period));
    assign w_slot      = ~r_out_valid | i_res_pop;

    assign o_result    = r_out;
    assign o_res_valid = r_out_valid;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (!i_cmd_empty) begin
                    if (i_cmd.first) begin
                        n_state = S_PUSH;
                    end else if (r_seeded) begin
                        n_state = S_SMUL;
                    end else if (w_seed_done) begin
                        n_state = S_DIVG_GO;
                    end else begin
                        n_state = S_PUSH;
                    end
                end
            end
            S_SMUL:      n_state = S_SADD;
            S_SADD:      n_state = S_DIVG_GO;
            S_DIVG_GO:   n_state = S_DIVG_WAIT;
            S_DIVG_WAIT: n_state = i_div_rsp.done ? S_DIVL_GO : S_DIVG_WAIT;
            S_DIVL_GO:   n_state = S_DIVL_WAIT;
            S_DIVL_WAIT: n_state = i_div_rsp.done ? S_RMUL : S_DIVL_WAIT;
            S_RMUL:      n_state = S_RADD;
            S_RADD:      n_state = (r_sum == '0) ? S_SIG : S_RDIV_GO;
            S_RDIV_GO:   n_state = S_RDIV_WAIT;
            S_RDIV_WAIT: n_state = i_div_rsp.done ? S_SIG : S_RDIV_WAIT;
            S_SIG:       n_state = S_PUSH;
            S_PUSH:      n_state = w_slot ? S_IDLE : S_PUSH;
            default:     n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd_pop       = 1'b0;
        o_div_req.start = 1'b0;
        o_div_req.rem0  = DEN_W'(r_num_g[SNUM_W-1:AVG_W]);
        o_div_req.low   = r_num_g[AVG_W-1:0];
        o_div_req.iters = ITER_W'(AVG_W);
        o_div_req.den   = DEN_W'(r_den_s);
        unique case (r_state)
            S_IDLE: begin
                o_cmd_pop = ~i_cmd_empty;
            end
            S_DIVG_GO: begin
                o_div_req.start = 1'b1;
            end
            S_DIVL_GO: begin
                o_div_req.start = 1'b1;
                o_div_req.rem0  = DEN_W'(r_num_l[SNUM_W-1:AVG_W]);
                o_div_req.low   = r_num_l[AVG_W-1:0];
            end
            S_RDIV_GO: begin
                o_div_req.start = 1'b1;
                o_div_req.rem0  = r_num_r[NUM_W-1:RSI_W];
                o_div_req.low   = {r_num_r[RSI_W-1:0], {(AVG_W-RSI_W){1'b0}}};
                o_div_req.iters = ITER_W'(RSI_W);
                o_div_req.den   = {r_sum, 1'b0};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_seeded <= 1'b0;
            r_count  <= '0;
            r_avg_g  <= '0;
            r_avg_l  <= '0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_IDLE: begin
                    if (!i_cmd_empty) begin
                        if (i_cmd.first) begin
                            r_seeded <= 1'b0;
                            r_count  <= '0;
                            r_avg_g  <= '0;
                            r_avg_l  <= '0;
                        end else if (!r_seeded) begin
                            r_avg_g <= w_sum_g;
                            r_avg_l <= w_sum_l;
                            if (w_seed_done) begin
                                r_seeded <= 1'b1;
                            end else begin
                                r_count <= w_cnt_next;
                            end
                        end
                    end
                end
                S_DIVG_WAIT: begin
                    if (i_div_rsp.done) begin
                        r_avg_g <= i_div_rsp.quo;
                    end
                end
                S_DIVL_WAIT: begin
                    if (i_div_rsp.done) begin
                        r_avg_l <= i_div_rsp.quo;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_gain  <= i_cmd.gain;
                r_loss  <= i_cmd.loss;
                r_num_g <= SNUM_W'(w_sum_g) << FRAC_W;
                r_num_l <= SNUM_W'(w_sum_l) << FRAC_W;
                r_den_s <= w_seed_done ? PERIOD_W'(w_cnt_next) : w_period;
                r_res   <= '{rsi_ready: 1'b0, rsi_value: '0, signal: SIG_HOLD};
            end
            S_SMUL: begin
                r_prod_g <= r_avg_g * w_nm1;
                r_prod_l <= r_avg_l * w_nm1;
                r_den_s  <= w_period;
            end
            S_SADD: begin
                r_num_g <= SNUM_W'(r_prod_g) + (SNUM_W'(r_gain) << FRAC_W);
                r_num_l <= SNUM_W'(r_prod_l) + (SNUM_W'(r_loss) << FRAC_W);
            end
            S_RMUL: begin
                r_prod_r <= r_avg_g * RMUL_W'(RSI_DOUBLE);
                r_sum    <= SUM_W'(r_avg_g) + SUM_W'(r_avg_l);
            end
            S_RADD: begin
                r_num_r <= NUM_W'(r_prod_r) + NUM_W'(r_sum);
                r_rsi   <= RSI_W'(RSI_HALF);
            end
            S_RDIV_WAIT: begin
                if (i_div_rsp.done) begin
                    r_rsi <= i_div_rsp.quo[RSI_W-1:0];
                end
            end
            S_SIG: begin
                r_res.rsi_ready <= 1'b1;
                r_res.rsi_value <= r_rsi;
                if (r_rsi < i_cfg.buy) begin
                    r_res.signal <= SIG_BUY;
                end else if (r_rsi > i_cfg.sell) begin
                    r_res.signal <= SIG_SELL;
                end else begin
                    r_res.signal <= SIG_HOLD;
                end
            end
            default: begin
            end
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (r_state == S_PUSH && w_slot) begin
            r_out <= r_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_PUSH && w_slot) begin
            r_out_valid <= 1'b1;
        end else if (i_res_pop) begin
            r_out_valid <= 1'b0;
        end
    end

endmodule

>>> rtl/rsi_threshold_signal.sv
// top level of the rsi threshold signal block
//
//   channel   handshake              payload
//   input     push / full            i_item   (price, restart)
//   result    empty / pop            o_result (rsi_ready, rsi_value, signal)
//   config    i_cfg_valid / ready    i_cfg_index, i_cfg_data
//
// a seeded sample is finished by the shared serial divider: two 40-bit quotients for the averages
// and one 14-bit quotient for rsi, which is skipped when both averages are zero; a sample that
// completes seeding skips the smoothing multiply and add, and other samples bypass the divider.
// a two-entry command queue lets the input side take transactions while the back works,
// and a result register holds the finished transaction until pop.
// reset is synchronous; it restores the register defaults and clears all history.
module rsi_threshold_signal (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    output logic                                full,
    input  rsi_pkg::t_item                      i_item,
    output logic                                empty,
    input  logic                                pop,
    output rsi_pkg::t_result                    o_result,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [rsi_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [rsi_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import rsi_pkg::*;

    t_cfg     r_cfg;
    t_cmd     w_cmd_in;
    t_cmd     w_cmd_head;
    logic     w_cmd_full;
    logic     w_cmd_empty;
    logic     w_cmd_pop;
    logic     w_accept;
    logic     w_res_valid;
    t_div_req w_div_req;
    t_div_rsp w_div_rsp;

    assign o_cfg_ready = 1'b1;
    assign full        = w_cmd_full;
    assign empty       = ~w_res_valid;
    assign w_accept    = push & ~w_cmd_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.period <= PERIOD_W'(RST_PERIOD);
            r_cfg.buy    <= THR_W'(RST_BUY);
            r_cfg.sell   <= THR_W'(RST_SELL);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_PERIOD: r_cfg.period <= i_cfg_data[PERIOD_W-1:0];
                CFG_BUY:    r_cfg.buy    <= i_cfg_data[THR_W-1:0];
                CFG_SELL:   r_cfg.sell   <= i_cfg_data[THR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    rsi_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_item   (i_item),
        .o_cmd    (w_cmd_in)
    );

    rsi_cmd_fifo u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept),
        .i_cmd   (w_cmd_in),
        .i_pop   (w_cmd_pop),
        .o_head  (w_cmd_head),
        .o_full  (w_cmd_full),
        .o_empty (w_cmd_empty)
    );

    rsi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    rsi_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd       (w_cmd_head),
        .i_cmd_empty (w_cmd_empty),
        .o_cmd_pop   (w_cmd_pop),
        .o_div_req   (w_div_req),
        .i_div_rsp   (w_div_rsp),
        .o_result    (o_result),
        .o_res_valid (w_res_valid),
        .i_res_pop   (pop)
    );

    a_cmd_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd_pop |-> !w_cmd_empty)
        else $error("command popped from an empty queue");

    a_div_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_req.start |-> !w_div_rsp.busy)
        else $error("divider started while busy");

    a_not_ready_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_result.rsi_ready) |->
            (o_result.rsi_value == '0 && o_result.signal == SIG_HOLD))
        else $error("not-ready result carries a value or signal");

    a_rsi_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.rsi_ready) |-> (o_result.rsi_value <= RSI_W'(RSI_SCALE)))
        else $error("rsi value out of range");

endmodule

>>> dv/tb.sv
// testbench for rsi_threshold_signal: directed table, then random price walks checked by a predictor
module tb;
    import rsi_pkg::*;

    localparam int ITEM_COUNT     = 850;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 300;
    localparam int DIR_ROWS       = 33;
    localparam logic [CNT_W-1:0] SEEDED = 7'd127;

    typedef logic [63:0] t_u64;
    typedef enum logic {ROW_ITEM, ROW_WRITE} t_row_kind;

    typedef struct packed {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_data;
        t_item                 txn;
        logic                  typed;
        t_result               want;
    } t_row;

    logic                  i_clk;
    logic                  i_rst_n = 1'b0;
    logic                  push = 1'b0;
    logic                  full;
    t_item                 i_item = '0;
    logic                  empty;
    logic                  pop = 1'b0;
    t_result               o_result;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = CFG_PERIOD;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // predictor copy of the registers and history
    logic [PERIOD_W-1:0] period_reg = PERIOD_W'(RST_PERIOD);
    logic [THR_W-1:0]    buy_reg = THR_W'(RST_BUY);
    logic [THR_W-1:0]    sell_reg = THR_W'(RST_SELL);
    logic [PRICE_W-1:0]  last_seen_price = '0;
    logic                have_last = 1'b0;
    logic [CNT_W-1:0]    changes_taken = '0;
    t_u64                gain_avg = '0;
    t_u64                loss_avg = '0;

    t_result expected_rsi [$];
    int      errors = 0;
    int      quiet_cycles = 0;
    int      items_sent = 0;
    bit      send_burst = 1'b0;

    t_row dir_rows [DIR_ROWS] = '{
        '{ROW_ITEM,  CFG_PERIOD, 14'd0, '{24'd100, 1'b0}, 1'b1, '{1'b0, 14'd0, SIG_HOLD}},
        '{ROW_ITEM,  CFG_PERIOD, 14'd0, '{24'd100, 1'b0}, 1'b1, '{1'b0, 14'd0, SIG_HOLD}},
        '{ROW_WRITE, CFG_PERIOD, 14'd2, '0, 1'b0, '0},
        '{ROW_ITEM,  CFG_PERIOD, 14'd0, '{24'd100, 1'b0}, 1'b1,
            '{1'b1, 14'(RSI_HALF), SIG_HOLD}},
        '{ROW_ITEM,  CFG_PERIOD, 14'd0, '{24'hFFFFFF, 1'b0}, 1'b1,
            '{1'b1, 14'(RSI_SCALE), SIG_SELL}},
        '{ROW_ITEM,  CFG_PERIOD, 14'd0, '{24'h000000, 1'b0}, 1'b0, '0},
        '{ROW_ITEM,  CFG_PERIOD, 14'd0, '{24'hFFFFFF, 1'b1}, 1'b1, '{1'b0, 14'd0, SIG_HOLD}},
        '{ROW_ITEM,  CFG_PERIOD, 14'd0, '{24'h000000, 1'b0}, 1'b1, '{1'b0, 14'd0, SIG_HOLD}},
        '{ROW_ITEM,  CFG_PERIOD, 14'd0, '{24'h000000, 1'b0}, 1'b1, '{1'b1, 14'd0, SIG_BUY}},
        '{ROW_WRITE, CFG_PERIOD, 14'd0, '0, 1'b0, '0},
        '{ROW_ITEM,  CFG_PERIOD, 14'd0, '{24'h800000, 1'b0}, 1'b0, '0},
        '{ROW_ITEM,  CFG_PERIOD, 14'd0, '{24'h7FFFFF, 1'b0}, 1'b0, '0},
        '{ROW_WRITE, CFG_BUY,    14'd0, '0, 1'b0, '0},
        '{ROW_WRITE, CFG_SELL,   14'(RSI_SCALE), '0, 1'b0, '0},
        '{ROW_ITEM,  CFG_PERIOD, 14'd0, '{24'hABCDEF, 1'b0}, 1'b0, '0},
        '{ROW_WRITE, CFG_BUY,    14'h3FFF, '0, 1'b0, '0},
        '{ROW_WRITE, CFG_SELL,   14'h3FFF, '0, 1'b0, '0},
        '{ROW_ITEM,  CFG_PERIOD, 14'd0, '{24'h000001, 1'b0}, 1'b0, '0},
        '{ROW_WRITE, CFG_BUY,    14'(RSI_SCALE), '0, 1'b0, '0},
        '{ROW_WRITE, CFG_SELL,   14'd0, '0, 1'b0, '0},
        '{ROW_ITEM,  CFG_PERIOD, 14'd0, '{24'h000001, 1'b0}, 1'b0, '0},
        '{ROW_ITEM,  CFG_PERIOD, 14'd0, '{24'h000002, 1'b0}, 1'b0, '0},
        '{ROW_WRITE, CFG_PERIOD, 14'd127, '0, 1'b0, '0},
        '{ROW_ITEM,  CFG_PERIOD, 14'd0, '{24'd5, 1'b0}, 1'b0, '0},
        '{ROW_ITEM,  CFG_PERIOD, 14'd0, '{24'd5, 1'b1}, 1'b1, '{1'b0, 14'd0, SIG_HOLD}},
        '{ROW_WRITE, CFG_PERIOD, 14'h3F83, '0, 1'b0, '0},
        '{ROW_ITEM,  CFG_PERIOD, 14'd0, '{24'd7, 1'b0}, 1'b1, '{1'b0, 14'd0, SIG_HOLD}},
        '{ROW_ITEM,  CFG_PERIOD, 14'd0, '{24'd6, 1'b0}, 1'b1, '{1'b0, 14'd0, SIG_HOLD}},
        '{ROW_ITEM,  CFG_PERIOD, 14'd0, '{24'd9, 1'b0}, 1'b0, '0},
        '{ROW_WRITE, CFG_PERIOD, 14'd1, '0, 1'b0, '0},
        '{ROW_WRITE, CFG_BUY,    14'(RST_BUY), '0, 1'b0, '0},
        '{ROW_WRITE, CFG_SELL,   14'(RST_SELL), '0, 1'b0, '0},
        '{ROW_ITEM,  CFG_PERIOD, 14'd0, '{24'h555555, 1'b0}, 1'b0, '0}
    };

    rsi_threshold_signal i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_item      (i_item),
        .empty       (empty),
        .pop         (pop),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    function automatic logic [RSI_W-1:0] rsi_from_avgs(t_u64 g, t_u64 l);
        t_u64 s;
        s = g + l;
        while (s[63:44] != '0) begin
            g = g >> 1;
            l = l >> 1;
            s = g + l;
        end
        if (s == '0)
            return RSI_W'(RSI_HALF);
        return RSI_W'((g * 64'(RSI_DOUBLE) + s) / (64'd2 * s));
    endfunction

    function automatic t_result predict_rsi_step(t_item txn);
        t_result r;
        t_u64 n, gain, loss, count, amask;
        r = '0;
        r.signal = SIG_HOLD;
        amask = (64'd1 << AVG_W) - 64'd1;
        n = (period_reg < PERIOD_MIN) ? 64'(PERIOD_MIN) :
            (period_reg > PERIOD_MAX) ? 64'(PERIOD_MAX) : 64'(period_reg);
        if (txn.restart || !have_last) begin
            last_seen_price = txn.price;
            have_last = 1'b1;
            changes_taken = '0;
            gain_avg = '0;
            loss_avg = '0;
        end else begin
            gain = '0;
            loss = '0;
            if (txn.price > last_seen_price)
                gain = 64'(txn.price) - 64'(last_seen_price);
            else
                loss = 64'(last_seen_price) - 64'(txn.price);
            last_seen_price = txn.price;
            if (changes_taken == SEEDED) begin
                gain_avg = ((gain_avg * (n - 1) + (gain << FRAC_W)) / n) & amask;
                loss_avg = ((loss_avg * (n - 1) + (loss << FRAC_W)) / n) & amask;
                r.rsi_ready = 1'b1;
            end else begin
                count = 64'(changes_taken) + 64'd1;
                gain_avg = gain_avg + gain;
                loss_avg = loss_avg + loss;
                if (count >= n) begin
                    gain_avg = ((gain_avg << FRAC_W) / count) & amask;
                    loss_avg = ((loss_avg << FRAC_W) / count) & amask;
                    changes_taken = SEEDED;
                    r.rsi_ready = 1'b1;
                end else begin
                    changes_taken = CNT_W'(count);
                end
            end
            if (r.rsi_ready) begin
                r.rsi_value = rsi_from_avgs(gain_avg, loss_avg);
                if (r.rsi_value < buy_reg)
                    r.signal = SIG_BUY;
                else if (r.rsi_value > sell_reg)
                    r.signal = SIG_SELL;
            end
        end
        return r;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // drift: 0 flat, 1 rising, 2 falling
    function automatic logic [PRICE_W-1:0] walk_price(logic [PRICE_W-1:0] last,
                                                      int unsigned drift);
        longint v;
        longint step;
        int unsigned sel;
        int unsigned up_pct;
        sel = $urandom_range(0, 99);
        if (sel < 3)
            return '0;
        if (sel < 6)
            return '1;
        if (sel < 14)
            return PRICE_W'($urandom);
        step = (sel < 70) ? $urandom_range(0, 40) : $urandom_range(0, 200000);
        up_pct = (drift == 1) ? 80 : (drift == 2) ? 20 : 50;
        v = longint'(last);
        v = ($urandom_range(0, 99) < up_pct) ? v + step : v - step;
        if (v < 0)
            v = 0;
        if (v > longint'({PRICE_W{1'b1}}))
            v = longint'({PRICE_W{1'b1}});
        return PRICE_W'(v);
    endfunction

    task automatic send_item(input t_item txn, input logic use_typed, input t_result typed_res);
        int unsigned gap;
        t_result res;
        gap = send_burst ? 0 : pick_gap();
        if (gap != 0) begin
            push <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        push <= 1'b1;
        i_item <= txn;
        do @(posedge i_clk); while (full !== 1'b0);
        res = predict_rsi_step(txn);
        if (use_typed)
            res = typed_res;
        expected_rsi = {expected_rsi, res};
        items_sent++;
        @(negedge i_clk);
    endtask

    // registers change only with nothing in flight
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        push <= 1'b0;
        while (expected_rsi.size() != 0)
            @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        case (idx)
            CFG_PERIOD: period_reg = data[PERIOD_W-1:0];
            CFG_BUY:    buy_reg = data;
            CFG_SELL:   sell_reg = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    initial begin : result_drain
        int unsigned stall;
        bit rx_steady;
        stall = 0;
        rx_steady = 1'b0;
        forever begin
            @(negedge i_clk);
            if ($urandom_range(0, 299) == 0)
                rx_steady = !rx_steady;
            if (stall != 0) begin
                pop <= 1'b0;
                stall--;
            end else begin
                pop <= 1'b1;
                if (!rx_steady && $urandom_range(0, 7) == 0)
                    stall = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        t_result want;
        if (!i_rst_n) begin
            quiet_cycles <= 0;
        end else begin
            if ((push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (pop && empty === 1'b0) begin
                if (expected_rsi.size() == 0) begin
                    $error("result transaction with nothing expected: %h", o_result);
                    errors++;
                end else begin
                    want = expected_rsi.pop_front();
                    if (o_result.rsi_ready !== want.rsi_ready) begin
                        $error("rsi_ready: expected %0d, got %0d",
                               want.rsi_ready, o_result.rsi_ready);
                        errors++;
                    end
                    if (o_result.rsi_value !== want.rsi_value) begin
                        $error("rsi_value: expected %0d, got %0d",
                               want.rsi_value, o_result.rsi_value);
                        errors++;
                    end
                    if (o_result.signal !== want.signal) begin
                        $error("signal: expected %0d, got %0d", want.signal, o_result.signal);
                        errors++;
                    end
                end
            end
        end
    end

    initial begin : watchdog
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    initial begin : stimulus
        logic [CFG_DATA_W-1:0] period_pick;
        logic [CFG_DATA_W-1:0] buy_pick;
        logic [CFG_DATA_W-1:0] sell_pick;
        logic [PRICE_W-1:0]    last_price;
        int unsigned           phase_len;
        int unsigned           drift;
        t_item                 txn;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int k = 0; k < DIR_ROWS; k++) begin
            if (dir_rows[k].kind == ROW_WRITE)
                write_reg(dir_rows[k].reg_idx, dir_rows[k].reg_data);
            else
                send_item(dir_rows[k].txn, dir_rows[k].typed, dir_rows[k].want);
        end
        last_price = dir_rows[DIR_ROWS-1].txn.price;

        while (items_sent < ITEM_COUNT) begin
            case ($urandom_range(0, 9))
                0: period_pick = CFG_DATA_W'($urandom_range(0, 1));
                1: period_pick = CFG_DATA_W'(PERIOD_MAX);
                2: period_pick = CFG_DATA_W'($urandom_range(PERIOD_MAX + 1, 127)) |
                                 CFG_DATA_W'($urandom_range(0, 127) << PERIOD_W);
                3: period_pick = CFG_DATA_W'($urandom_range(9, 20));
                default: period_pick = CFG_DATA_W'($urandom_range(PERIOD_MIN, 8));
            endcase
            case ($urandom_range(0, 7))
                0: begin
                    buy_pick = '0;
                    sell_pick = CFG_DATA_W'(RSI_SCALE);
                end
                1: begin
                    buy_pick = CFG_DATA_W'(RSI_SCALE);
                    sell_pick = '0;
                end
                2: begin
                    buy_pick = CFG_DATA_W'($urandom);
                    sell_pick = CFG_DATA_W'($urandom);
                end
                default: begin
                    buy_pick = CFG_DATA_W'($urandom_range(1000, 4500));
                    sell_pick = CFG_DATA_W'($urandom_range(5500, 9000));
                end
            endcase
            if ($urandom_range(0, 3) != 0)
                write_reg(CFG_PERIOD, period_pick);
            if ($urandom_range(0, 2) != 0)
                write_reg(CFG_BUY, buy_pick);
            if ($urandom_range(0, 2) != 0)
                write_reg(CFG_SELL, sell_pick);

            phase_len = $urandom_range(20, 100);
            drift = $urandom_range(0, 2);
            send_burst = ($urandom_range(0, 3) == 0);
            repeat (phase_len) begin
                txn.restart = ($urandom_range(0, 49) == 0);
                txn.price = walk_price(last_price, drift);
                last_price = txn.price;
                send_item(txn, 1'b0, '0);
            end
        end

        push <= 1'b0;
        while (expected_rsi.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
